>>> design/adc_cal_pkg.sv
// Shared types and constants for the ADC sample calibrator.
// No dependencies; imported by every module of the block.
package adc_cal_pkg;

  // Port and field widths
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned ChW    = 6;
  localparam int unsigned WordW  = 32;
  localparam int unsigned VoltW  = 48;
  localparam int unsigned StatW  = 3;

  // Datapath widths
  localparam int unsigned CodeW  = 24;          // diagnostic and sample codes
  localparam int unsigned ProdW  = 2 * CodeW;   // |s-o| * vref
  localparam int unsigned NumW   = ProdW + 6;   // times 64
  localparam int unsigned DenW   = CodeW + 2;   // 3 * gain
  localparam int unsigned QuadW  = 26;          // corrected value below 3.0 in Q24
  localparam int unsigned SqW    = 28;          // c*c >> 24
  localparam int unsigned PolyW  = 29;          // quadratic fit coefficient

  // Divider: quotient bits resolved per stage
  localparam int unsigned DivBps    = 2;
  localparam int unsigned DivStages = NumW / DivBps;

  // Fixed-point constants, Q24
  localparam logic [CodeW-1:0] BiasHalf = 24'h800000;    // 0.5
  localparam logic [CodeW-1:0] BiasCh2  = 24'd5452595;   // 0.325
  localparam logic [NumW-1:0]  ThreeQ24 = 54'h3000000;   // 3.0
  localparam logic [PolyW-1:0] KConst   = 29'd253335962; // 15.1
  localparam logic [CodeW-1:0] KLin     = 24'd14143193;  // 0.843
  localparam logic [21:0]      KQuad    = 22'd2674288;   // 0.1594
  localparam logic [VoltW-1:0] PosMax   = 48'h7FFF_FFFF_FFFF;
  localparam logic [VoltW-1:0] NegMin   = 48'h8000_0000_0000;

  typedef enum logic [StatW-1:0] {
    StOk          = 3'd0,
    StBadChan     = 3'd1,
    StSampleByte  = 3'd2,
    StDiagByte    = 3'd3,
    StDiagInvalid = 3'd4,
    StNegDomain   = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpecialGain = 1'b0,
    CfgHighGain    = 1'b1
  } cfg_idx_e;

  // Per-item control that travels beside the data
  typedef struct packed {
    status_e    status;
    logic       special;   // channels one to three
    logic [1:0] bsel;      // low channel bits, picks the bias
    logic       dneg;      // sample below offset
  } meta_t;

endpackage

>>> design/adc_cal_front.sv
// Front stages: word checks, offset removal and the reference product.
// Depends on adc_cal_pkg.
module adc_cal_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [adc_cal_pkg::ChW-1:0]   channel_i,
  input  logic [adc_cal_pkg::WordW-1:0] sample_word_i,
  input  logic [adc_cal_pkg::WordW-1:0] offset_word_i,
  input  logic [adc_cal_pkg::WordW-1:0] vref_word_i,
  input  logic [adc_cal_pkg::WordW-1:0] gain_word_i,
  input  logic [adc_cal_pkg::WordW-1:0] supply_word_i,
  input  logic [adc_cal_pkg::WordW-1:0] temp_word_i,
  output logic                          valid_o,
  output adc_cal_pkg::meta_t            meta_o,
  output logic [adc_cal_pkg::NumW-1:0]  num_o,
  output logic [adc_cal_pkg::DenW-1:0]  den_o
);
  import adc_cal_pkg::*;

  logic              diag_byte;
  logic              diag_zero;
  logic [CodeW:0]    diff;
  logic [CodeW:0]    diff_abs;
  meta_t             meta_d;

  logic              v0_q;
  meta_t             meta0_q;
  logic [CodeW-1:0]  dmag0_q;
  logic [CodeW-1:0]  vref0_q;
  logic [CodeW-1:0]  gain0_q;

  logic              v1_q;
  meta_t             meta1_q;
  logic [ProdW-1:0]  prod1_q;
  logic [DenW-1:0]   den1_q;

  // Check the words and take the signed difference
  always_comb begin
    diag_byte = (|offset_word_i[WordW-1:CodeW]) | (|vref_word_i[WordW-1:CodeW]) |
                (|gain_word_i[WordW-1:CodeW]) | (|supply_word_i[WordW-1:CodeW]) |
                (|temp_word_i[WordW-1:CodeW]);
    diag_zero = (temp_word_i[CodeW-1:0] == '0) || (vref_word_i[CodeW-1:0] == '0) ||
                (supply_word_i[CodeW-1:0] == '0) || (gain_word_i[CodeW-1:0] == '0);
    diff      = {sample_word_i[CodeW-1], sample_word_i[CodeW-1:0]} -
                {offset_word_i[CodeW-1], offset_word_i[CodeW-1:0]};
    diff_abs  = diff[CodeW] ? (~diff + 1'b1) : diff;

    meta_d.special = (channel_i >= ChW'(1)) && (channel_i <= ChW'(3));
    meta_d.bsel    = channel_i[1:0];
    meta_d.dneg    = diff[CodeW];
    priority if (channel_i[ChW-1]) begin
      meta_d.status = StBadChan;
    end else if (|sample_word_i[WordW-1:CodeW]) begin
      meta_d.status = StSampleByte;
    end else if (diag_byte) begin
      meta_d.status = StDiagByte;
    end else if (diag_zero) begin
      meta_d.status = StDiagInvalid;
    end else if (diff[CodeW] && !meta_d.special) begin
      meta_d.status = StNegDomain;
    end else begin
      meta_d.status = StOk;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  // Stage 0 holds the checked codes, stage 1 the product and divisor
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      meta0_q <= meta_d;
      dmag0_q <= diff_abs[CodeW-1:0];
      vref0_q <= vref_word_i[CodeW-1:0];
      gain0_q <= gain_word_i[CodeW-1:0];
      meta1_q <= meta0_q;
      prod1_q <= ProdW'(dmag0_q) * ProdW'(vref0_q);
      den1_q  <= DenW'(gain0_q) + {1'b0, gain0_q, 1'b0};
    end
  end

  assign valid_o = v1_q;
  assign meta_o  = meta1_q;
  assign num_o   = {prod1_q, 6'b0};
  assign den_o   = den1_q;

endmodule

>>> design/adc_cal_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on adc_cal_pkg.
module adc_cal_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  adc_cal_pkg::meta_t            meta_i,
  input  logic [adc_cal_pkg::NumW-1:0]  num_i,
  input  logic [adc_cal_pkg::DenW-1:0]  den_i,
  output logic                          valid_o,
  output adc_cal_pkg::meta_t            meta_o,
  output logic [adc_cal_pkg::NumW-1:0]  quo_o
);
  import adc_cal_pkg::*;

  logic [DivStages-1:0] v_q;
  meta_t                meta_q [DivStages];
  logic [DenW-1:0]      rem_q  [DivStages];
  logic [NumW-1:0]      num_q  [DivStages];
  logic [NumW-1:0]      quo_q  [DivStages];
  logic [DenW-1:0]      den_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic            v_in;
    meta_t           meta_in;
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] num_in;
    logic [NumW-1:0] quo_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] num_d;
    logic [NumW-1:0] quo_d;

    if (s == 0) begin : g_head
      assign v_in    = valid_i;
      assign meta_in = meta_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
    end else begin : g_body
      assign v_in    = v_q[s-1];
      assign meta_in = meta_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
    end

    // Resolve the next quotient bits: shift in a dividend bit, subtract if it fits
    always_comb begin
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      trial = '0;
      for (int k = 0; k < DivBps; k++) begin
        trial = {rem_d, num_d[NumW-1]};
        num_d = {num_d[NumW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          quo_d = {quo_d[NumW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[NumW-2:0], 1'b0};
        end
        rem_d = trial[DenW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        meta_q[s] <= meta_in;
        rem_q[s]  <= rem_d;
        num_q[s]  <= num_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
      end
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign meta_o  = meta_q[DivStages-1];
  assign quo_o   = quo_q[DivStages-1];

endmodule

>>> design/adc_cal_post.sv
// Back stages: bias and gain with saturation, quadratic fit, result select.
// Depends on adc_cal_pkg.
module adc_cal_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  adc_cal_pkg::meta_t            meta_i,
  input  logic [adc_cal_pkg::NumW-1:0]  cmag_i,
  input  logic [adc_cal_pkg::CfgW-1:0]  special_gain_i,
  input  logic [adc_cal_pkg::CfgW-1:0]  high_gain_i,
  output logic                          valid_o,
  output logic [adc_cal_pkg::VoltW-1:0] voltage_o,
  output logic [adc_cal_pkg::StatW-1:0] status_o
);
  import adc_cal_pkg::*;

  localparam int unsigned LoW  = 32;
  localparam int unsigned HiW  = NumW - LoW;
  localparam int unsigned QW   = HiW + CfgW + 16;
  localparam int unsigned RW   = QuadW + PolyW;

  // Stage 1 inputs
  logic [NumW-1:0]  bias;
  logic [NumW-1:0]  mag_d;
  logic             neg_d;
  logic [QuadW-1:0] c_d;

  logic [4:0]             v_q;
  meta_t                  meta1_q, meta2_q, meta3_q, meta4_q;
  logic                   neg1_q, neg2_q, neg3_q;
  logic                   quad1_q, quad2_q, quad3_q, quad4_q;
  logic [NumW-1:0]        mag1_q;
  logic [CfgW-1:0]        gain1_q;
  logic [QuadW-1:0]       c1_q, c2_q, c3_q;
  logic [2*QuadW-1:0]     sq1_q;
  logic [QuadW+CodeW-1:0] lin1_q;
  logic [LoW+CfgW-1:0]    plo2_q;
  logic [HiW+CfgW-1:0]    phi2_q;
  logic [QuadW-1:0]       t1_2_q;
  logic [SqW+22-1:0]      t2_2_q;
  logic [QW-1:0]          q3_q;
  logic [PolyW-1:0]       p3_q;
  logic [VoltW-1:0]       gval4_q;
  logic [RW-1:0]          r4_q;
  logic [VoltW-1:0]       volt5_q;
  logic [StatW-1:0]       stat5_q;

  // Stage 4 saturation
  logic [QW-1:0]    limit;
  logic [VoltW-1:0] gval_d;

  // Apply the channel bias and pick the gain
  always_comb begin
    bias  = (meta_i.bsel == 2'd2) ? NumW'(BiasCh2) : NumW'(BiasHalf);
    mag_d = cmag_i;
    neg_d = 1'b0;
    if (meta_i.special) begin
      if (meta_i.dneg) begin
        mag_d = cmag_i + bias;
        neg_d = 1'b1;
      end else if (cmag_i >= bias) begin
        mag_d = cmag_i - bias;
      end else begin
        mag_d = bias - cmag_i;
        neg_d = 1'b1;
      end
    end
    c_d = cmag_i[QuadW-1:0];
  end

  // Clamp the scaled magnitude and apply the sign
  always_comb begin
    limit = neg3_q ? QW'(NegMin) : QW'(PosMax);
    if (q3_q > limit) begin
      gval_d = neg3_q ? NegMin : PosMax;
    end else begin
      gval_d = neg3_q ? (~q3_q[VoltW-1:0] + 1'b1) : q3_q[VoltW-1:0];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Stage 1: biased magnitude, fit squares
      meta1_q <= meta_i;
      neg1_q  <= neg_d;
      mag1_q  <= mag_d;
      gain1_q <= meta_i.special ? special_gain_i : high_gain_i;
      quad1_q <= !meta_i.special && (cmag_i < ThreeQ24);
      c1_q    <= c_d;
      sq1_q   <= (2*QuadW)'(c_d) * (2*QuadW)'(c_d);
      lin1_q  <= (QuadW+CodeW)'(c_d) * (QuadW+CodeW)'(KLin);
      // Stage 2: gain partial products, quadratic term
      meta2_q <= meta1_q;
      neg2_q  <= neg1_q;
      quad2_q <= quad1_q;
      c2_q    <= c1_q;
      plo2_q  <= (LoW+CfgW)'(mag1_q[LoW-1:0]) * (LoW+CfgW)'(gain1_q);
      phi2_q  <= (HiW+CfgW)'(mag1_q[NumW-1:LoW]) * (HiW+CfgW)'(gain1_q);
      t1_2_q  <= lin1_q[QuadW+CodeW-1:CodeW];
      t2_2_q  <= (SqW+22)'(sq1_q[2*QuadW-1:CodeW]) * (SqW+22)'(KQuad);
      // Stage 3: combine partials, fit coefficient
      meta3_q <= meta2_q;
      neg3_q  <= neg2_q;
      quad3_q <= quad2_q;
      c3_q    <= c2_q;
      q3_q    <= {phi2_q, 16'b0} + QW'(plo2_q[LoW+CfgW-1:16]);
      p3_q    <= KConst + PolyW'(t1_2_q) - PolyW'(t2_2_q[SqW+22-1:CodeW]);
      // Stage 4: saturated gain result, fit product
      meta4_q <= meta3_q;
      quad4_q <= quad3_q;
      gval4_q <= gval_d;
      r4_q    <= RW'(c3_q) * RW'(p3_q);
      // Stage 5: select the result, zero it on error
      stat5_q <= meta4_q.status;
      if (meta4_q.status != StOk) begin
        volt5_q <= '0;
      end else if (quad4_q) begin
        volt5_q <= VoltW'(r4_q[RW-1:CodeW]);
      end else begin
        volt5_q <= gval4_q;
      end
    end
  end

  assign valid_o   = v_q[4];
  assign voltage_o = volt5_q;
  assign status_o  = stat5_q;

endmodule

>>> design/adc_sample_calibrator_top.sv
// Stages from item accept to result valid: 2 front, 27 divider and 5 back.
// Throughput: one item per cycle while the result is not stalled; the 54-bit
// quotient is resolved two bits per stage in the divider pipeline.
// A stalled result holds the whole pipeline in place.
// Reset clears all valid bits and sets both gain registers to 1.0.
// Top level of the ADC sample calibrator. Depends on adc_cal_pkg,
// adc_cal_front, adc_cal_div and adc_cal_post.
module adc_sample_calibrator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [adc_cal_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [adc_cal_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [adc_cal_pkg::ChW-1:0]     channel_i,
  input  logic [adc_cal_pkg::WordW-1:0]   sample_word_i,
  input  logic [adc_cal_pkg::WordW-1:0]   offset_word_i,
  input  logic [adc_cal_pkg::WordW-1:0]   vref_word_i,
  input  logic [adc_cal_pkg::WordW-1:0]   gain_word_i,
  input  logic [adc_cal_pkg::WordW-1:0]   supply_word_i,
  input  logic [adc_cal_pkg::WordW-1:0]   temp_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [adc_cal_pkg::VoltW-1:0] voltage_o,
  output logic [adc_cal_pkg::StatW-1:0]   status_o
);
  import adc_cal_pkg::*;

  logic            adv;
  logic [CfgW-1:0] special_gain_q;
  logic [CfgW-1:0] high_gain_q;
  logic            fr_valid;
  meta_t           fr_meta;
  logic [NumW-1:0] fr_num;
  logic [DenW-1:0] fr_den;
  logic            dv_valid;
  meta_t           dv_meta;
  logic [NumW-1:0] dv_quo;
  logic [VoltW-1:0] volt;

  // Advance everything unless a result is waiting
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Hold the gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_gain_q <= CfgW'(65536);
      high_gain_q    <= CfgW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSpecialGain: special_gain_q <= cfg_wdata_i;
        CfgHighGain:    high_gain_q    <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  adc_cal_front u_front (
    .clk_i, .rst_ni,
    .adv_i         (adv),
    .valid_i       (in_valid_i && in_ready_o),
    .channel_i, .sample_word_i, .offset_word_i, .vref_word_i,
    .gain_word_i, .supply_word_i, .temp_word_i,
    .valid_o       (fr_valid),
    .meta_o        (fr_meta),
    .num_o         (fr_num),
    .den_o         (fr_den)
  );

  adc_cal_div u_div (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (fr_valid),
    .meta_i  (fr_meta),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .valid_o (dv_valid),
    .meta_o  (dv_meta),
    .quo_o   (dv_quo)
  );

  adc_cal_post u_post (
    .clk_i, .rst_ni,
    .adv_i          (adv),
    .valid_i        (dv_valid),
    .meta_i         (dv_meta),
    .cmag_i         (dv_quo),
    .special_gain_i (special_gain_q),
    .high_gain_i    (high_gain_q),
    .valid_o        (out_valid_o),
    .voltage_o      (volt),
    .status_o       (status_o)
  );

  assign voltage_o = volt;

`ifndef NO_ASSERTIONS
  // Any error code comes with a zero voltage
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> voltage_o == '0)
    else $error("error result with nonzero voltage");

  // Input is refused only while a result waits
  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without output stall");

  // A waiting result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(voltage_o) && $stable(status_o))
    else $error("stalled result changed");
`endif

endmodule

>>> verif/tb_adc_sample_calibrator_top.sv
// Self-checking testbench for adc_sample_calibrator_top: random and directed
// samples, predicted in-bench and compared in order. Depends on adc_cal_pkg.
module tb_adc_sample_calibrator_top;
  import adc_cal_pkg::*;

  // Expected calibrated outputs, oldest first
  class cal_scoreboard;
    logic [VoltW-1:0] exp_volt_q[$];
    logic [StatW-1:0] exp_stat_q[$];
    int               mismatches;

    function void note_item(logic [VoltW-1:0] v, logic [StatW-1:0] s);
      exp_volt_q.push_back(v);
      exp_stat_q.push_back(s);
    endfunction

    function void check_result(logic [VoltW-1:0] v, logic [StatW-1:0] s);
      logic [VoltW-1:0] ev;
      logic [StatW-1:0] es;
      if (exp_volt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result v=%h s=%0d", v, s);
        return;
      end
      ev = exp_volt_q.pop_front();
      es = exp_stat_q.pop_front();
      if (ev !== v || es !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp v=%h s=%0d, got v=%h s=%0d", ev, es, v, s);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ChW-1:0] channel_i = '0;
  logic [WordW-1:0] sample_word_i = '0, offset_word_i = '0, vref_word_i = '0;
  logic [WordW-1:0] gain_word_i = '0, supply_word_i = '0, temp_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VoltW-1:0] voltage_o;
  logic [StatW-1:0] status_o;

  logic [31:0] special_gain_q = 32'd65536;
  logic [31:0] high_gain_q = 32'd65536;
  bit stall_enable = 1'b1;
  cal_scoreboard calib_sb;

  adc_sample_calibrator_top uut (.*);

  always #5 clk_i = ~clk_i;

  // Magnitude times Q16.16 gain, truncated, saturated against limit
  function automatic logic [VoltW-1:0] apply_gain(bit neg, logic [63:0] mag,
                                                  logic [31:0] g);
    logic [95:0] prod;
    logic [95:0] lim;
    prod = ({32'd0, mag} * {64'd0, g}) >> 16;
    lim = neg ? (96'd1 << 47) : ((96'd1 << 47) - 1);
    if (prod > lim) return neg ? NegMin : PosMax;
    return neg ? -prod[VoltW-1:0] : prod[VoltW-1:0];
  endfunction

  function automatic logic signed [63:0] code24(logic [31:0] w);
    return {{40{w[23]}}, w[23:0]};
  endfunction

  // Compute the calibrated voltage and status of one sample
  task automatic predict_calibration(input logic [5:0] ch, input logic [31:0] sw,
      input logic [31:0] ow, input logic [31:0] vw, input logic [31:0] gw,
      input logic [31:0] pw, input logic [31:0] tw,
      output logic [VoltW-1:0] v, output logic [StatW-1:0] st);
    logic signed [63:0] d;
    logic [63:0] dmag, cmag, b, c2, p, vref, g;
    bit dneg;
    logic [127:0] wide;
    v = '0;
    st = StOk;
    if (ch >= 32) st = StBadChan;
    else if (sw[31:24] != 0) st = StSampleByte;
    else if (ow[31:24] != 0 || vw[31:24] != 0 || gw[31:24] != 0 ||
             pw[31:24] != 0 || tw[31:24] != 0) st = StDiagByte;
    else if (tw[23:0] == 0 || vw[23:0] == 0 || pw[23:0] == 0 || gw[23:0] == 0)
      st = StDiagInvalid;
    else begin
      vref = vw[23:0];
      g = gw[23:0];
      d = code24(sw) - code24(ow);
      dneg = d < 0;
      dmag = dneg ? -d : d;
      cmag = (dmag * vref * 64) / (3 * g);
      if (ch >= 1 && ch <= 3) begin
        b = (ch == 2) ? 64'd5452595 : 64'h800000;
        if (dneg) v = apply_gain(1, cmag + b, special_gain_q);
        else if (cmag >= b) v = apply_gain(0, cmag - b, special_gain_q);
        else v = apply_gain(1, b - cmag, special_gain_q);
      end else if (dneg) st = StNegDomain;
      else if (cmag >= (64'd3 << 24)) v = apply_gain(0, cmag, high_gain_q);
      else begin
        c2 = (cmag * cmag) >> 24;
        p = 64'd253335962 + ((64'd14143193 * cmag) >> 24) - ((64'd2674288 * c2) >> 24);
        wide = {64'd0, cmag} * {64'd0, p};
        v = wide[24 +: VoltW];
      end
    end
    if (st != StOk) v = '0;
  endtask

  // Offer one sample and wait for acceptance
  task automatic send_sample(input logic [5:0] ch, input logic [31:0] sw,
      input logic [31:0] ow, input logic [31:0] vw, input logic [31:0] gw,
      input logic [31:0] pw, input logic [31:0] tw);
    logic [VoltW-1:0] v;
    logic [StatW-1:0] st;
    predict_calibration(ch, sw, ow, vw, gw, pw, tw, v, st);
    channel_i <= ch; sample_word_i <= sw; offset_word_i <= ow;
    vref_word_i <= vw; gain_word_i <= gw; supply_word_i <= pw; temp_word_i <= tw;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    calib_sb.note_item(v, st);
  endtask

  task automatic idle_sender(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Let the pipeline empty before touching a register
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (calib_sb.exp_volt_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Pulse one register write and track the new gain in the bench
  task automatic write_gain(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSpecialGain) special_gain_q = val; else high_gain_q = val;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_code();
    case ($urandom_range(0, 5))
      0: return 32'h00FFFFFF;
      1: return 32'h00800000;
      2: return $urandom_range(1, 255);
      default: return {8'd0, 24'($urandom())};
    endcase
  endfunction

  // Mostly well-formed samples with random content, some broken ones
  task automatic send_random();
    logic [5:0] ch;
    logic [31:0] w[6];
    int k;
    ch = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 3)) : 6'($urandom());
    if ($urandom_range(0, 3) != 0) ch[5] = 1'b0;
    foreach (w[i]) w[i] = rand_code();
    if (w[1][23:0] == 0) w[1] = 1;
    if (w[2][23:0] == 0) w[2] = 1;
    if (w[3][23:0] == 0) w[3] = 1;
    if (w[4][23:0] == 0) w[4] = 1;
    if ($urandom_range(0, 4) == 0) w[2] = 32'($urandom_range(1, 255));
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 5);
      w[k] = ($urandom_range(0, 1) != 0) ? $urandom() | 32'h01000000
                                         : w[k] & 32'hFF000000;
    end
    send_sample(ch, w[0], w[1], w[2], w[3], w[4], w[5]);
  endtask

  task automatic random_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_random();
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // Receiver stalls in runs of random length while enabled; taken results are checked
  always @(posedge clk_i) begin
    if (!stall_enable) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 7) == 0) out_ready_i <= ~out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) calib_sb.check_result(voltage_o, status_o);
  end

  initial begin
    #5_000_000;
    $display("tb_adc_sample_calibrator_top: done, errors");
    $finish;
  end

  initial begin
    calib_sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and every status
    send_sample(6'd0, 32'h7FFFFF, 32'h800000, 32'hFFFFFF, 32'h1, 32'h1, 32'h1);
    send_sample(6'd63, 0, 0, 1, 1, 1, 1);
    send_sample(6'd32, 0, 0, 1, 1, 1, 1);
    send_sample(6'd4, 32'hFF000000, 0, 1, 1, 1, 1);
    send_sample(6'd4, 0, 32'h01000000, 1, 1, 1, 1);
    send_sample(6'd4, 0, 0, 32'hFFFFFFFF, 1, 1, 1);
    send_sample(6'd4, 0, 0, 1, 32'h80000000, 1, 1);
    send_sample(6'd4, 0, 0, 1, 1, 32'hFF000001, 1);
    send_sample(6'd4, 0, 0, 1, 1, 1, 32'h02000000);
    send_sample(6'd4, 0, 0, 0, 1, 1, 1);
    send_sample(6'd4, 0, 0, 1, 0, 1, 1);
    send_sample(6'd4, 0, 0, 1, 1, 0, 1);
    send_sample(6'd4, 0, 0, 1, 1, 1, 0);
    send_sample(6'd5, 32'h000000, 32'h000001, 1, 32'hFFFFFF, 1, 1);
    send_sample(6'd5, 32'h800000, 32'h7FFFFF, 32'hFFFFFF, 1, 1, 1);
    send_sample(6'd31, 32'h100000, 0, 32'h400000, 32'h400000, 1, 1);
    send_sample(6'd31, 32'h7FFFFF, 32'h800000, 32'hFFFFFF, 32'hFFFFFF, 1, 1);
    send_sample(6'd1, 0, 0, 1, 1, 1, 1);
    send_sample(6'd2, 32'h800000, 32'h7FFFFF, 32'hFFFFFF, 1, 1, 1);
    send_sample(6'd3, 32'h7FFFFF, 32'h800000, 32'hFFFFFF, 1, 1, 1);
    send_sample(6'd2, 32'h000100, 0, 32'h0C0000, 32'h000001, 1, 1);
    random_phase(300);

    // Sweep gain settings, extremes included, with the pipeline idle
    drain_results();
    write_gain(CfgSpecialGain, 32'hFFFFFFFF);
    write_gain(CfgHighGain, 32'hFFFFFFFF);
    random_phase(300);
    drain_results();
    write_gain(CfgSpecialGain, 32'h0);
    write_gain(CfgHighGain, 32'h0);
    random_phase(300);
    drain_results();
    write_gain(CfgSpecialGain, $urandom());
    write_gain(CfgHighGain, $urandom());
    stall_enable = 1'b0;
    random_phase(300);
    stall_enable = 1'b1;
    drain_results();
    write_gain(CfgSpecialGain, $urandom_range(0, 32'h3FFFF));
    write_gain(CfgHighGain, $urandom_range(32'h8000, 32'h30000));
    random_phase(600);

    // Wait for the tail of the pipeline
    drain_results();
    if (calib_sb.mismatches == 0)
      $display("tb_adc_sample_calibrator_top: done, clean");
    else
      $display("tb_adc_sample_calibrator_top: done, errors");
    $finish;
  end
endmodule

>>> files.f
design/adc_cal_pkg.sv
design/adc_cal_front.sv
design/adc_cal_div.sv
design/adc_cal_post.sv
design/adc_sample_calibrator_top.sv
verif/tb_adc_sample_calibrator_top.sv
